[rtl/core/rcf_pkg.sv]
// Package for the RGB color fader core: item payload types and operation codes.
// Depends on nothing; used by rgb_color_fader_core.
`default_nettype none

package rcf_pkg;

   // Operation codes carried by an input item.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Strip kind codes.
   localparam logic STRIP_RGB         = 1'b0;
   localparam logic STRIP_ADDRESSABLE = 1'b1;

   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned COUNT_W = 31;

   typedef struct packed {
      logic               operation;
      logic [COUNT_W-1:0] loop_count;
      logic [LEVEL_W-1:0] start_red;
      logic [LEVEL_W-1:0] start_green;
      logic [LEVEL_W-1:0] start_blue;
      logic [LEVEL_W-1:0] goal_red;
      logic [LEVEL_W-1:0] goal_green;
      logic [LEVEL_W-1:0] goal_blue;
      logic               strip_kind;
      logic [LEVEL_W-1:0] step_size;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
      logic               transition_done;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/rgb_color_fader_core.sv]
// RGB color fader core: top level with tick qualification pipeline and fade state.
// Depends on rcf_pkg for the item payload types and operation codes.
`default_nettype none

//  Channel | Ports                        | Direction | Payload
//  --------+------------------------------+-----------+--------------------
//  request | req_valid req_ready req_data | in        | rcf_pkg::req_type
//  result  | rsp_valid rsp_ready rsp_data | out       | rcf_pkg::rsp_type
//
// One item is accepted per cycle while the input stage has room. An item passes
// through an input register, a register after the reciprocal multiply of the loop
// count, and a register that holds the "multiple of TICK_PERIOD" flag, and then its
// result shows in the output register. These stages are set by the two multiplies
// of the period test; the fade state updates as an item leaves the flag register.
// Reset clears every stage valid, the output valid and the fade state (step size
// resets to one). A stalled result only holds back stages that have no room to
// move, so bubbles in front of it are still filled by new items.

module rgb_color_fader_core #(
   parameter int unsigned TICK_PERIOD = 100
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  rcf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output rcf_pkg::rsp_type rsp_data
);

   // The period test uses an exact reciprocal: for a 31-bit count n and
   // L = ceil(log2(TICK_PERIOD)), floor(n * ceil(2^(31+L) / P) / 2^(31+L))
   // equals floor(n / P). The reciprocal always fits in 32 bits.
   localparam int unsigned COUNT_W = rcf_pkg::COUNT_W;
   localparam int unsigned LEVEL_W = rcf_pkg::LEVEL_W;
   localparam int unsigned SHIFT   = COUNT_W + $clog2(TICK_PERIOD);
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(TICK_PERIOD) - 64'd1) / 64'(TICK_PERIOD);
   localparam logic [31:0] RECIP   = RECIP_WIDE[31:0];
   localparam logic [15:0] PERIOD  = 16'(TICK_PERIOD);
   localparam int unsigned PROD_W  = COUNT_W + 32;
   localparam int unsigned BACK_W  = COUNT_W + 16;

   // Moves one channel toward its goal by at most step, landing on the goal
   // instead of passing it.
   function automatic logic [LEVEL_W-1:0] move_toward(
      input logic [LEVEL_W-1:0] cur,
      input logic [LEVEL_W-1:0] goal,
      input logic [LEVEL_W-1:0] step
   );
      logic [LEVEL_W-1:0] result;
      if (cur < goal) begin
         result = ((goal - cur) <= step) ? goal : cur + step;
      end else if (cur > goal) begin
         result = ((cur - goal) <= step) ? goal : cur - step;
      end else begin
         result = cur;
      end
      return result;
   endfunction

   // Pipeline stage registers.
   logic               s1_valid_ff, s1_valid_in;
   rcf_pkg::req_type   s1_data_ff,  s1_data_in;
   logic               s2_valid_ff, s2_valid_in;
   rcf_pkg::req_type   s2_data_ff,  s2_data_in;
   logic [COUNT_W-1:0] s2_quo_ff,   s2_quo_in;
   logic               s3_valid_ff, s3_valid_in;
   rcf_pkg::req_type   s3_data_ff,  s3_data_in;
   logic               s3_mult_ff,  s3_mult_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   rcf_pkg::rsp_type   rsp_data_ff,  rsp_data_in;

   // Fade state.
   logic [LEVEL_W-1:0] level_red_ff,   level_red_in;
   logic [LEVEL_W-1:0] level_green_ff, level_green_in;
   logic [LEVEL_W-1:0] level_blue_ff,  level_blue_in;
   logic [LEVEL_W-1:0] aim_red_ff,     aim_red_in;
   logic [LEVEL_W-1:0] aim_green_ff,   aim_green_in;
   logic [LEVEL_W-1:0] aim_blue_ff,    aim_blue_in;
   logic [LEVEL_W-1:0] stride_ff,      stride_in;
   logic               strip_is_rgb_ff, strip_is_rgb_in;
   logic               active_ff,      active_in;

   // Stage advance chain: a stage moves when the one after it has room.
   logic adv1, adv2, adv3;
   logic accept;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  quo_wide;
   logic [BACK_W-1:0]  back;
   logic               s3_is_start;
   logic               step_now;
   logic               all_equal;
   logic [LEVEL_W-1:0] next_red, next_green, next_blue;

   assign adv3      = !rsp_valid_ff || rsp_ready;
   assign adv2      = !s3_valid_ff || adv3;
   assign adv1      = !s2_valid_ff || adv2;
   assign req_ready = !s1_valid_ff || adv1;
   assign accept    = req_valid && req_ready;

   // First half of the period test: the reciprocal product of the count.
   assign prod     = PROD_W'(s1_data_ff.loop_count) * PROD_W'(RECIP);
   assign quo_wide = prod >> SHIFT;

   // Second half: the count is a multiple when quotient times period gives it
   // back. The product never exceeds the count, so the low bits suffice.
   assign back = BACK_W'(s2_quo_ff) * BACK_W'(PERIOD);

   // Final stage: the fade step itself.
   assign s3_is_start = (s3_data_ff.operation == rcf_pkg::OP_START);
   assign step_now    = s3_valid_ff && adv3 && !s3_is_start && active_ff &&
                        s3_mult_ff && strip_is_rgb_ff;
   assign all_equal   = (level_red_ff == aim_red_ff) &&
                        (level_green_ff == aim_green_ff) &&
                        (level_blue_ff == aim_blue_ff);
   assign next_red    = move_toward(level_red_ff, aim_red_ff, stride_ff);
   assign next_green  = move_toward(level_green_ff, aim_green_ff, stride_ff);
   assign next_blue   = move_toward(level_blue_ff, aim_blue_ff, stride_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end

      s2_valid_in = s2_valid_ff;
      s2_data_in  = s2_data_ff;
      s2_quo_in   = s2_quo_ff;
      if (adv1) begin
         s2_valid_in = s1_valid_ff;
         s2_data_in  = s1_data_ff;
         s2_quo_in   = quo_wide[COUNT_W-1:0];
      end

      s3_valid_in = s3_valid_ff;
      s3_data_in  = s3_data_ff;
      s3_mult_in  = s3_mult_ff;
      if (adv2) begin
         s3_valid_in = s2_valid_ff;
         s3_data_in  = s2_data_ff;
         s3_mult_in  = (back[COUNT_W-1:0] == s2_data_ff.loop_count);
      end
   end

   always_comb begin
      level_red_in    = level_red_ff;
      level_green_in  = level_green_ff;
      level_blue_in   = level_blue_ff;
      aim_red_in      = aim_red_ff;
      aim_green_in    = aim_green_ff;
      aim_blue_in     = aim_blue_ff;
      stride_in       = stride_ff;
      strip_is_rgb_in = strip_is_rgb_ff;
      active_in       = active_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (s3_valid_ff && adv3 && s3_is_start) begin
         // A start item restarts the transition from any state.
         level_red_in    = s3_data_ff.start_red;
         level_green_in  = s3_data_ff.start_green;
         level_blue_in   = s3_data_ff.start_blue;
         aim_red_in      = s3_data_ff.goal_red;
         aim_green_in    = s3_data_ff.goal_green;
         aim_blue_in     = s3_data_ff.goal_blue;
         stride_in       = s3_data_ff.step_size;
         strip_is_rgb_in = (s3_data_ff.strip_kind == rcf_pkg::STRIP_RGB);
         active_in       = 1'b1;
      end else if (step_now) begin
         level_red_in   = next_red;
         level_green_in = next_green;
         level_blue_in  = next_blue;
         if (all_equal) begin
            active_in = 1'b0;
         end
         rsp_valid_in                = 1'b1;
         rsp_data_in.red_level       = next_red;
         rsp_data_in.green_level     = next_green;
         rsp_data_in.blue_level      = next_blue;
         rsp_data_in.transition_done = all_equal;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         level_red_ff    <= '0;
         level_green_ff  <= '0;
         level_blue_ff   <= '0;
         aim_red_ff      <= '0;
         aim_green_ff    <= '0;
         aim_blue_ff     <= '0;
         stride_ff       <= LEVEL_W'(1);
         strip_is_rgb_ff <= 1'b0;
         active_ff       <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         s3_valid_ff     <= s3_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         level_red_ff    <= level_red_in;
         level_green_ff  <= level_green_in;
         level_blue_ff   <= level_blue_in;
         aim_red_ff      <= aim_red_in;
         aim_green_ff    <= aim_green_in;
         aim_blue_ff     <= aim_blue_in;
         stride_ff       <= stride_in;
         strip_is_rgb_ff <= strip_is_rgb_in;
         active_ff       <= active_in;
      end
      // Payload registers carry no reset.
      s1_data_ff  <= s1_data_in;
      s2_data_ff  <= s2_data_in;
      s2_quo_ff   <= s2_quo_in;
      s3_data_ff  <= s3_data_in;
      s3_mult_ff  <= s3_mult_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Ready only drops while the input stage holds an item that cannot move.
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff))
      else $error("input stalled with room in the pipeline");

   // A finished transition leaves the block idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (step_now && all_equal) |=> !active_ff)
      else $error("block still active after a done result");

   // A done result reports the levels sitting on their targets.
   a_done_levels: assert property (@(posedge clock) disable iff (reset)
      (step_now && all_equal) |=>
         (rsp_data.red_level == $past(aim_red_ff)) &&
         (rsp_data.green_level == $past(aim_green_ff)) &&
         (rsp_data.blue_level == $past(aim_blue_ff)))
      else $error("done result with levels off target");

   // No result is produced from an item that is not a qualified tick.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(step_now))
      else $error("result appeared without a fade step");

endmodule

`default_nettype wire

[bench/rgb_color_fader_core_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for rgb_color_fader_core: directed and random fades with random
// idling on both sides. Depends on rcf_pkg and rgb_color_fader_core.

module rgb_color_fader_core_test;

   localparam int unsigned COUNT_W = rcf_pkg::COUNT_W;
   localparam int unsigned TICK_PERIOD = 100;
   // Largest multiple of the period that fits in the 31-bit count, divided by the period.
   localparam int unsigned MAX_TICK_INDEX = 21474836;
   localparam int unsigned RANDOM_ITEMS = 600;
   localparam int unsigned CYCLE_LIMIT = 200000;
   // Results trail acceptance through the pipeline; leave some margin at the end.
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned LONG_HOLD = 120;

   typedef struct {
      rcf_pkg::req_type item;
      bit               wait_idle;   // hold this item back until no result is outstanding
   } offer_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   rcf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b1;
   rcf_pkg::rsp_type rsp_data;

   offer_type        offer_queue[$];
   rcf_pkg::rsp_type fade_expected[$];

   int unsigned item_total = 0;
   int unsigned sent_count = 0;
   int unsigned fault_count = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   bit          hold_used = 1'b0;

   // Predicted fade state, updated on every accepted item.
   logic [7:0] cur_red = 8'd0, cur_green = 8'd0, cur_blue = 8'd0;
   logic [7:0] tgt_red = 8'd0, tgt_green = 8'd0, tgt_blue = 8'd0;
   logic [7:0] step_amt = 8'd1;
   logic       rgb_strip = 1'b0;
   logic       fading = 1'b0;

   rgb_color_fader_core #(
      .TICK_PERIOD(TICK_PERIOD)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // One channel moves by the stride toward its goal and stops on it instead of passing it.
   function automatic logic [7:0] approach(logic [7:0] level, logic [7:0] goal,
                                           logic [7:0] stride);
      if (level < goal) begin
         return (goal - level <= stride) ? goal : level + stride;
      end else if (level > goal) begin
         return (level - goal <= stride) ? goal : level - stride;
      end
      return level;
   endfunction

   // Applies one accepted item to the predicted state and queues the result it causes, if any.
   task automatic fade_predict(input rcf_pkg::req_type it);
      rcf_pkg::rsp_type res;
      logic             all_there;
      if (it.operation == rcf_pkg::OP_START) begin
         cur_red   = it.start_red;
         cur_green = it.start_green;
         cur_blue  = it.start_blue;
         tgt_red   = it.goal_red;
         tgt_green = it.goal_green;
         tgt_blue  = it.goal_blue;
         rgb_strip = (it.strip_kind == rcf_pkg::STRIP_RGB);
         step_amt  = it.step_size;
         fading    = 1'b1;
      end else if (fading && (it.loop_count % TICK_PERIOD) == 0 && rgb_strip) begin
         // The done flag looks at the levels before this step moves them.
         all_there = (cur_red == tgt_red) && (cur_green == tgt_green) &&
                     (cur_blue == tgt_blue);
         cur_red   = approach(cur_red, tgt_red, step_amt);
         cur_green = approach(cur_green, tgt_green, step_amt);
         cur_blue  = approach(cur_blue, tgt_blue, step_amt);
         if (all_there) begin
            fading = 1'b0;
         end
         res.red_level       = cur_red;
         res.green_level     = cur_green;
         res.blue_level      = cur_blue;
         res.transition_done = all_there;
         fade_expected.push_back(res);
      end
   endtask

   task automatic push_start(input logic [7:0] sr, input logic [7:0] sg, input logic [7:0] sb,
                             input logic [7:0] gr, input logic [7:0] gg, input logic [7:0] gb,
                             input logic kind, input logic [7:0] stride, input bit hold);
      offer_type o;
      o.item.operation   = rcf_pkg::OP_START;
      o.item.loop_count  = COUNT_W'($urandom);   // ignored on a start
      o.item.start_red   = sr;
      o.item.start_green = sg;
      o.item.start_blue  = sb;
      o.item.goal_red    = gr;
      o.item.goal_green  = gg;
      o.item.goal_blue   = gb;
      o.item.strip_kind  = kind;
      o.item.step_size   = stride;
      o.wait_idle        = hold;
      offer_queue.push_back(o);
      item_total++;
   endtask

   // Color and step fields of a tick are don't-care, so they carry random junk.
   task automatic push_tick(input logic [COUNT_W-1:0] count);
      offer_type o;
      o.item.operation   = rcf_pkg::OP_TICK;
      o.item.loop_count  = count;
      o.item.start_red   = 8'($urandom);
      o.item.start_green = 8'($urandom);
      o.item.start_blue  = 8'($urandom);
      o.item.goal_red    = 8'($urandom);
      o.item.goal_green  = 8'($urandom);
      o.item.goal_blue   = 8'($urandom);
      o.item.strip_kind  = 1'($urandom);
      o.item.step_size   = 8'($urandom);
      o.wait_idle        = 1'b0;
      offer_queue.push_back(o);
      item_total++;
   endtask

   // Mostly counts on the period so that steps actually execute.
   function automatic logic [COUNT_W-1:0] pick_count();
      if ($urandom_range(0, 99) < 85) begin
         return COUNT_W'($urandom_range(0, MAX_TICK_INDEX) * TICK_PERIOD);
      end
      return COUNT_W'($urandom);
   endfunction

   function automatic logic [7:0] pick_stride();
      case ($urandom_range(0, 9))
         0: begin
            return 8'd0;
         end
         1, 2, 3, 4: begin
            return 8'($urandom_range(1, 8));
         end
         5, 6, 7: begin
            return 8'($urandom_range(9, 64));
         end
         default: begin
            return 8'($urandom_range(65, 255));
         end
      endcase
   endfunction

   // Idling stops near the end of the run and in every third window of 64 items.
   function automatic bit idling_off();
      return (offer_queue.size() < 80) || (((sent_count >> 6) % 3) == 2);
   endfunction

   task automatic compare_level(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fault_count++;
      end
   endtask

   // Stimulus and end of run.
   initial begin
      logic [7:0] sr, sg, sb, gr, gg, gb;
      int unsigned ticks;

      // Tick before any start: the block is idle and stays silent.
      push_tick('0);
      // Full-scale fade with the largest step: clamps at the goal, then finishes.
      push_start(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, rcf_pkg::STRIP_RGB, 8'd255, 1'b0);
      push_tick(31'd99);
      push_tick(31'd100);
      push_tick(31'd2147483600);
      push_tick('0);                    // idle again after done
      // Downward fade by one, started only once no result is outstanding.
      push_start(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, rcf_pkg::STRIP_RGB, 8'd1, 1'b1);
      push_tick(31'h7FFF_FFFF);         // not on the period
      push_tick(31'd200);
      // Zero step restarts an active fade; the levels never move.
      push_start(8'd10, 8'd200, 8'd128, 8'd200, 8'd10, 8'd128, rcf_pkg::STRIP_RGB, 8'd0, 1'b0);
      push_tick(31'd300);
      push_tick(31'd400);
      // Mixed directions with a step that lands on the goal only by clamping.
      push_start(8'd5, 8'd250, 8'd77, 8'd9, 8'd246, 8'd77, rcf_pkg::STRIP_RGB, 8'd3, 1'b0);
      push_tick(31'd500);
      push_tick(31'd600);
      push_tick(31'd700);
      // Addressable strip: executed ticks give nothing and the block stays active.
      push_start(8'h12, 8'h34, 8'h56, 8'hFE, 8'h01, 8'h80, rcf_pkg::STRIP_ADDRESSABLE, 8'd5,
                 1'b0);
      push_tick('0);
      push_tick(31'd1000);
      // Already at the goal: the first step reports done.
      push_start(8'hAA, 8'h55, 8'hF0, 8'hAA, 8'h55, 8'hF0, rcf_pkg::STRIP_RGB, 8'h80, 1'b0);
      push_tick(31'd800);
      push_tick(31'd900);
      // Back-to-back starts; only the second one counts.
      push_start(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, rcf_pkg::STRIP_RGB, 8'hFF, 1'b0);
      push_start(8'd100, 8'd150, 8'd200, 8'd0, 8'd255, 8'd127, rcf_pkg::STRIP_RGB, 8'd64, 1'b0);
      push_tick(31'd1100);
      push_tick(31'd1200);

      // Random fades: each is a start with random colors followed by a run of ticks.
      // Zero ticks gives a restart; stray ticks between fades add noise.
      while (item_total < RANDOM_ITEMS + 25) begin
         if ($urandom_range(0, 9) == 0) begin
            push_tick(COUNT_W'($urandom));
         end
         sr = 8'($urandom);
         sg = 8'($urandom);
         sb = 8'($urandom);
         if ($urandom_range(0, 6) == 0) begin
            gr = sr;
            gg = sg;
            gb = sb;
         end else begin
            gr = 8'($urandom);
            gg = 8'($urandom);
            gb = 8'($urandom);
         end
         push_start(sr, sg, sb, gr, gg, gb,
                    ($urandom_range(0, 9) == 0) ? rcf_pkg::STRIP_ADDRESSABLE
                                                : rcf_pkg::STRIP_RGB,
                    pick_stride(), $urandom_range(0, 19) == 0);
         ticks = $urandom_range(0, 20);
         repeat (ticks) push_tick(pick_count());
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (offer_queue.size() != 0 || req_valid || fade_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Driver: presents queued items, predicts on acceptance, and inserts random gaps.
   // A gap only starts right after an item is taken, so valid never drops early.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            fade_predict(req_data);
            sent_count <= sent_count + 1;
            if (!idling_off() && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(1, 15);
            end
         end
         if (req_valid && !req_ready) begin
            // Keep offering the same item until it is taken.
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (offer_queue.size() != 0 &&
                      !(offer_queue[0].wait_idle && fade_expected.size() != 0)) begin
            req_data  <= offer_queue[0].item;
            req_valid <= 1'b1;
            offer_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure. One long hold-off lets the pipeline fill and stall the
   // input while the driver keeps offering; otherwise short random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_used && sent_count >= 250) begin
         hold_used = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!idling_off() && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: every accepted result is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (fade_expected.size() == 0) begin
            $display("%0t ns: result with none expected, actual %0d/%0d/%0d done %0d",
                     $time, rsp_data.red_level, rsp_data.green_level,
                     rsp_data.blue_level, rsp_data.transition_done);
            fault_count++;
         end else begin
            compare_level("red_level", 32'(fade_expected[0].red_level),
                          32'(rsp_data.red_level));
            compare_level("green_level", 32'(fade_expected[0].green_level),
                          32'(rsp_data.green_level));
            compare_level("blue_level", 32'(fade_expected[0].blue_level),
                          32'(rsp_data.blue_level));
            compare_level("transition_done", 32'(fade_expected[0].transition_done),
                          32'(rsp_data.transition_done));
            void'(fade_expected.pop_front());
         end
      end
   end

   // Watchdog on the cycle count.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
